### rtl/clis_pkg.sv
`timescale 1ns / 1ps

package clis_pkg;

  // display geometry
  localparam int unsigned ROWS    = 2;
  localparam int unsigned COLUMNS = 16;

  // stream widths
  localparam int unsigned OP_W        = 3;
  localparam int unsigned TDATA_IN_W  = 56;
  localparam int unsigned TDATA_OUT_W = 24;

  // decimal conversion
  localparam int unsigned MAG_W      = 32;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned STEP_W     = 5;
  localparam int unsigned IDX_W      = 4;
  localparam logic [IDX_W-1:0] DIGIT_MAX = IDX_W'(NUM_DIGITS - 1);
  localparam logic [IDX_W-1:0] INIT_LAST = 4'd3;

  // LCD constants
  localparam logic [7:0] FUNC_SET_8BIT = 8'h38;
  localparam logic [7:0] FUNC_SET_4BIT = 8'h28;
  localparam logic [7:0] DISPLAY_ON    = 8'h0F;
  localparam logic [7:0] CLEAR_DISPLAY = 8'h01;
  localparam logic [7:0] ENTRY_MODE    = 8'h06;
  localparam logic [7:0] LONE_NIBBLE   = 8'h20;
  localparam logic [7:0] DDRAM_BASE    = 8'h80;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_MINUS    = 8'h2D;
  localparam logic [5:0] INIT_WAIT_MS  = 6'd35;
  localparam logic [1:0] SETTLE_MS     = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_INIT = 3'd0,
    OP_CMD  = 3'd1,
    OP_DATA = 3'd2,
    OP_GOTO = 3'd3,
    OP_INT  = 3'd4
  } op_e;

  // where the byte of the current transfer comes from
  typedef enum logic [2:0] {
    SRC_LONE  = 3'd0,
    SRC_INIT  = 3'd1,
    SRC_BYTE  = 3'd2,
    SRC_ADDR  = 3'd3,
    SRC_MINUS = 3'd4,
    SRC_DIGIT = 3'd5
  } src_e;

  typedef enum logic [1:0] {
    HALF_FULL = 2'd0,
    HALF_HIGH = 2'd1,
    HALF_LOW  = 2'd2
  } half_e;

  typedef struct packed {
    logic             capture;
    logic             conv_start;
    logic             load;
    src_e             src;
    logic [IDX_W-1:0] idx;
    half_e            half;
    logic             first;
    logic             last;
    logic             err;
  } cmd_t;

  typedef struct packed {
    logic             bus_mode;
    logic             out_free;
    logic             conv_busy;
    logic             negative;
    logic             range_ok;
    logic [IDX_W-1:0] msd_idx;
  } sts_t;

  function automatic logic [7:0] init_byte(input logic [IDX_W-1:0] idx, input logic bus_mode);
    logic [7:0] b;
    case (idx)
      4'd0:    b = bus_mode ? FUNC_SET_4BIT : FUNC_SET_8BIT;
      4'd1:    b = DISPLAY_ON;
      4'd2:    b = CLEAR_DISPLAY;
      default: b = ENTRY_MODE;
    endcase
    return b;
  endfunction

endpackage

### rtl/char_lcd_interface_sequencer.sv
`timescale 1ns / 1ps

// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tuser opcode, tdata byte/row/column/number
// m_axis    out  tvalid/tready/tlast    tuser RS, tdata bus/wait/settle/valid/status
// cfg       in   cfg_we_i               cfg_wdata_i bus_mode (1 = four-bit bus)
//
// One request at a time. Command, data and goto are accepted, give one send step per
// result and then a closing state; init gives 4 (eight-bit) or 9 (four-bit) results.
// Integers run the bit-serial BCD conversion before the digits.
// One result leaves per cycle while m_axis_tready_i is high; a stall holds the
// output register and the sequencer. Reset sets bus_mode to four-bit.
module char_lcd_interface_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,   // byte_value, row, column, number
  input  logic [2:0]  s_axis_tuser_i,   // opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // bus_value, wait_before_ms, settle_after_ms,
                                        // transfer_valid, status, zero pad
  output logic        m_axis_tuser_o,   // register_select
  output logic        m_axis_tlast_o
);

  clis_pkg::cmd_t cmd;
  clis_pkg::sts_t sts;

  clis_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .op_i      (s_axis_tuser_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  clis_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (s_axis_tuser_i),
    .data_i      (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_data_o    (m_axis_tdata_o),
    .m_rs_o      (m_axis_tuser_o),
    .m_last_o    (m_axis_tlast_o)
  );

endmodule

### rtl/clis_bcd.sv
`timescale 1ns / 1ps

// shift-and-add-3 binary to BCD, one bit per cycle
module clis_bcd (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [clis_pkg::MAG_W-1:0]      mag_i,
  output logic                            busy_o,
  output logic [clis_pkg::BCD_W-1:0]      bcd_o
);

  logic [clis_pkg::MAG_W-1:0]  bin_q, bin_d;
  logic [clis_pkg::BCD_W-1:0]  bcd_q, bcd_d, adj;
  logic [clis_pkg::STEP_W-1:0] step_q, step_d;
  logic                        busy_q, busy_d;

  always_comb begin
    for (int i = 0; i < clis_pkg::NUM_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    step_d = step_q;
    busy_d = busy_q;
    if (start_i) begin
      bin_d  = mag_i;
      bcd_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d  = {adj[clis_pkg::BCD_W-2:0], bin_q[clis_pkg::MAG_W-1]};
      bin_d  = {bin_q[clis_pkg::MAG_W-2:0], 1'b0};
      step_d = step_q + 1'b1;
      if (step_q == '1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign busy_o = busy_q;
  assign bcd_o  = bcd_q;

endmodule

### rtl/clis_datapath.sv
`timescale 1ns / 1ps

module clis_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i,
  input  logic [clis_pkg::OP_W-1:0]           op_i,
  input  logic [clis_pkg::TDATA_IN_W-1:0]     data_i,
  input  clis_pkg::cmd_t                      cmd_i,
  output clis_pkg::sts_t                      sts_o,
  output logic                                m_valid_o,
  input  logic                                m_ready_i,
  output logic [clis_pkg::TDATA_OUT_W-1:0]    m_data_o,
  output logic                                m_rs_o,
  output logic                                m_last_o
);

  logic                                 bus_mode_q;
  logic [clis_pkg::OP_W-1:0]            op_q;
  logic [7:0]                           byte_q, row_q, col_q;
  logic                                 neg_q;
  logic [clis_pkg::MAG_W-1:0]           num_in, mag;
  logic                                 conv_busy;
  logic [clis_pkg::BCD_W-1:0]           bcd;
  logic [clis_pkg::IDX_W-1:0]           msd;
  logic [3:0]                           digit;
  logic [7:0]                           row_m1, col_m1, addr, sel_byte, bus;
  logic                                 rs;
  logic [5:0]                           wait_ms;
  logic [1:0]                           settle;
  logic                                 m_valid_q;
  logic [clis_pkg::TDATA_OUT_W-1:0]     m_data_q;
  logic                                 m_rs_q, m_last_q;
  logic                                 out_free;

  assign num_in = data_i[55:24];
  assign mag    = num_in[clis_pkg::MAG_W-1] ? (~num_in + 1'b1) : num_in;

  clis_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.conv_start),
    .mag_i   (mag),
    .busy_o  (conv_busy),
    .bcd_o   (bcd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      bus_mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_i;
      byte_q <= data_i[7:0];
      row_q  <= data_i[15:8];
      col_q  <= data_i[23:16];
      neg_q  <= num_in[clis_pkg::MAG_W-1];
    end
  end

  // most significant nonzero digit, zero prints as one digit
  always_comb begin
    msd = '0;
    for (int i = 1; i < clis_pkg::NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) msd = clis_pkg::IDX_W'(i);
    end
  end

  always_comb begin
    digit = 4'd0;
    for (int i = 0; i < clis_pkg::NUM_DIGITS; i++) begin
      if (cmd_i.idx == clis_pkg::IDX_W'(i)) digit = bcd[4*i +: 4];
    end
  end

  assign row_m1 = row_q - 8'd1;
  assign col_m1 = col_q - 8'd1;
  assign addr   = clis_pkg::DDRAM_BASE + {row_m1[1:0], 6'd0} + col_m1;

  always_comb begin
    sel_byte = byte_q;
    rs       = 1'b0;
    unique case (cmd_i.src)
      clis_pkg::SRC_LONE:  sel_byte = clis_pkg::LONE_NIBBLE;
      clis_pkg::SRC_INIT:  sel_byte = clis_pkg::init_byte(cmd_i.idx, bus_mode_q);
      clis_pkg::SRC_BYTE: begin
        sel_byte = byte_q;
        rs       = (op_q == clis_pkg::OP_DATA);
      end
      clis_pkg::SRC_ADDR:  sel_byte = addr;
      clis_pkg::SRC_MINUS: begin
        sel_byte = clis_pkg::CHAR_MINUS;
        rs       = 1'b1;
      end
      clis_pkg::SRC_DIGIT: begin
        sel_byte = clis_pkg::CHAR_ZERO | {4'd0, digit};
        rs       = 1'b1;
      end
      default: sel_byte = byte_q;
    endcase
  end

  always_comb begin
    case (cmd_i.half)
      clis_pkg::HALF_HIGH: bus = {4'd0, sel_byte[7:4]};
      clis_pkg::HALF_LOW:  bus = {4'd0, sel_byte[3:0]};
      default:             bus = sel_byte;
    endcase
  end

  assign wait_ms = cmd_i.first ? clis_pkg::INIT_WAIT_MS : 6'd0;
  assign settle  = (cmd_i.half == clis_pkg::HALF_HIGH) ? 2'd0 : clis_pkg::SETTLE_MS;

  assign out_free = !m_valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  // tdata: bus[7:0] wait[13:8] settle[15:14] valid[16] status[17]
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_last_q <= cmd_i.last;
      if (cmd_i.err) begin
        m_data_q <= {6'd0, 1'b1, 1'b0, 2'd0, 6'd0, 8'd0};
        m_rs_q   <= 1'b0;
      end else begin
        m_data_q <= {6'd0, 1'b0, 1'b1, settle, wait_ms, bus};
        m_rs_q   <= rs;
      end
    end
  end

  assign sts_o.bus_mode  = bus_mode_q;
  assign sts_o.out_free  = out_free;
  assign sts_o.conv_busy = conv_busy;
  assign sts_o.negative  = neg_q;
  assign sts_o.range_ok  = (row_q >= 8'd1) && (row_q <= 8'(clis_pkg::ROWS)) &&
                           (col_q >= 8'd1) && (col_q <= 8'(clis_pkg::COLUMNS));
  assign sts_o.msd_idx   = msd;

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_rs_o    = m_rs_q;
  assign m_last_o  = m_last_q;

endmodule

### rtl/clis_ctrl.sv
`timescale 1ns / 1ps

module clis_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_valid_i,
  output logic                        s_ready_o,
  input  logic [clis_pkg::OP_W-1:0]   op_i,
  input  clis_pkg::sts_t              sts_i,
  output clis_pkg::cmd_t              cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SEND = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e                     state_q, state_d;
  clis_pkg::src_e             src_q, src_d;
  logic [clis_pkg::IDX_W-1:0] idx_q, idx_d;
  clis_pkg::half_e            half_q, half_d;
  logic                       first_q, first_d;
  clis_pkg::half_e            half_start;
  clis_pkg::op_e              op;
  logic                       byte_last, err;

  assign half_start = sts_i.bus_mode ? clis_pkg::HALF_HIGH : clis_pkg::HALF_FULL;
  assign op         = clis_pkg::op_e'(op_i);
  assign s_ready_o  = (state_q == S_IDLE);

  assign byte_last = ((src_q == clis_pkg::SRC_INIT) && (idx_q == clis_pkg::INIT_LAST)) ||
                     (src_q == clis_pkg::SRC_BYTE) || (src_q == clis_pkg::SRC_ADDR) ||
                     ((src_q == clis_pkg::SRC_DIGIT) && (idx_q == '0));
  assign err       = (src_q == clis_pkg::SRC_ADDR) && !sts_i.range_ok;

  always_comb begin
    state_d = state_q;
    src_d   = src_q;
    idx_d   = idx_q;
    half_d  = half_q;
    first_d = first_q;

    cmd_o.capture    = 1'b0;
    cmd_o.conv_start = 1'b0;
    cmd_o.load       = 1'b0;
    cmd_o.src        = src_q;
    cmd_o.idx        = idx_q;
    cmd_o.half       = half_q;
    cmd_o.first      = first_q;
    cmd_o.err        = err;
    cmd_o.last       = err || (byte_last && (half_q != clis_pkg::HALF_HIGH));

    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          idx_d         = '0;
          half_d        = half_start;
          first_d       = 1'b0;
          unique case (op) inside
            clis_pkg::OP_INIT: begin
              src_d   = sts_i.bus_mode ? clis_pkg::SRC_LONE : clis_pkg::SRC_INIT;
              first_d = 1'b1;
              state_d = S_SEND;
            end
            clis_pkg::OP_CMD, clis_pkg::OP_DATA: begin
              src_d   = clis_pkg::SRC_BYTE;
              state_d = S_SEND;
            end
            clis_pkg::OP_GOTO: begin
              src_d   = clis_pkg::SRC_ADDR;
              state_d = S_SEND;
            end
            clis_pkg::OP_INT: begin
              cmd_o.conv_start = 1'b1;
              state_d          = S_CONV;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_CONV: begin
        if (!sts_i.conv_busy) begin
          src_d   = sts_i.negative ? clis_pkg::SRC_MINUS : clis_pkg::SRC_DIGIT;
          idx_d   = sts_i.msd_idx;
          state_d = S_SEND;
        end
      end
      S_SEND: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          first_d    = 1'b0;
          if (err) begin
            state_d = S_DONE;
          end else if (src_q == clis_pkg::SRC_LONE) begin
            // lone wake-up nibble, then function set as two nibbles
            src_d  = clis_pkg::SRC_INIT;
            idx_d  = '0;
            half_d = clis_pkg::HALF_HIGH;
          end else if (half_q == clis_pkg::HALF_HIGH) begin
            half_d = clis_pkg::HALF_LOW;
          end else if (byte_last) begin
            state_d = S_DONE;
          end else begin
            half_d = half_start;
            case (src_q)
              clis_pkg::SRC_MINUS: begin
                src_d = clis_pkg::SRC_DIGIT;
                idx_d = sts_i.msd_idx;
              end
              clis_pkg::SRC_DIGIT: idx_d = idx_q - 1'b1;
              default:             idx_d = idx_q + 1'b1;
            endcase
          end
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      src_q   <= clis_pkg::SRC_BYTE;
      idx_q   <= '0;
      half_q  <= clis_pkg::HALF_FULL;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      src_q   <= src_d;
      idx_q   <= idx_d;
      half_q  <= half_d;
      first_q <= first_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> sts_i.out_free)
    else $error("result loaded while output register is occupied");

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && cmd_o.err) |-> cmd_o.last)
    else $error("range error result not marked last");

  a_conv_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.conv_start |=> (sts_i.conv_busy && state_q == S_CONV))
    else $error("conversion did not start");

  a_digit_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEND && src_q == clis_pkg::SRC_DIGIT) |-> (idx_q <= clis_pkg::DIGIT_MAX))
    else $error("digit index out of range");
`endif

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam logic [7:0]  ROW_STRIDE   = 8'h40;
  localparam logic [2:0]  OP_SPARE_LO  = 3'd5;  // opcodes from here up are ignored
  localparam logic [2:0]  OP_SPARE_HI  = 3'd7;
  localparam int unsigned DRAIN_CYCLES = 64;    // integer conversion is the slowest path
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned BATCH_ITEMS  = 35;

  typedef struct packed {
    logic       rs;
    logic [7:0] bus;
    logic [5:0] wait_ms;
    logic [1:0] settle_ms;
    logic       xfer;
    logic       status;
    logic       last;
  } lcd_xfer_t;

  class lcd_xfer_scoreboard;
    lcd_xfer_t   expected_xfers[$];
    logic        bus4 = 1'b1;
    int unsigned errors = 0;

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function void push_xfer(logic rs, logic [7:0] bus, logic [5:0] wait_ms,
                            logic [1:0] settle_ms, logic xfer, logic status);
      lcd_xfer_t x;
      x.rs = rs; x.bus = bus; x.wait_ms = wait_ms; x.settle_ms = settle_ms;
      x.xfer = xfer; x.status = status; x.last = 1'b0;
      expected_xfers.push_back(x);
    endfunction

    function void push_byte(logic rs, logic [7:0] b, logic [5:0] wait_ms);
      if (bus4) begin
        push_xfer(rs, {4'h0, b[7:4]}, wait_ms, 2'd0, 1'b1, 1'b0);
        push_xfer(rs, {4'h0, b[3:0]}, 6'd0, clis_pkg::SETTLE_MS, 1'b1, 1'b0);
      end else begin
        push_xfer(rs, b, wait_ms, clis_pkg::SETTLE_MS, 1'b1, 1'b0);
      end
    endfunction

    // expected transfers for one accepted request
    function void note_request(logic [2:0] op, logic [7:0] byte_value, logic [7:0] row,
                               logic [7:0] column, logic [31:0] number);
      int unsigned start;
      logic [31:0] mag;
      logic [3:0]  digs[clis_pkg::NUM_DIGITS];
      int          cnt;
      start = expected_xfers.size();
      case (op)
        clis_pkg::OP_INIT: begin
          if (bus4) begin
            push_xfer(1'b0, clis_pkg::LONE_NIBBLE >> 4, clis_pkg::INIT_WAIT_MS, 2'd0,
                      1'b1, 1'b0);
            push_byte(1'b0, clis_pkg::FUNC_SET_4BIT, 6'd0);
          end else begin
            push_byte(1'b0, clis_pkg::FUNC_SET_8BIT, clis_pkg::INIT_WAIT_MS);
          end
          push_byte(1'b0, clis_pkg::DISPLAY_ON, 6'd0);
          push_byte(1'b0, clis_pkg::CLEAR_DISPLAY, 6'd0);
          push_byte(1'b0, clis_pkg::ENTRY_MODE, 6'd0);
        end
        clis_pkg::OP_CMD:  push_byte(1'b0, byte_value, 6'd0);
        clis_pkg::OP_DATA: push_byte(1'b1, byte_value, 6'd0);
        clis_pkg::OP_GOTO: begin
          if (row >= 1 && row <= clis_pkg::ROWS && column >= 1 && column <= clis_pkg::COLUMNS)
            push_byte(1'b0, 8'(clis_pkg::DDRAM_BASE + ROW_STRIDE * (row - 8'd1) +
                               (column - 8'd1)), 6'd0);
          else
            push_xfer(1'b0, 8'd0, 6'd0, 2'd0, 1'b0, 1'b1);
        end
        clis_pkg::OP_INT: begin
          mag = number;
          if (number[31]) begin
            push_byte(1'b1, clis_pkg::CHAR_MINUS, 6'd0);
            mag = ~number + 32'd1;
          end
          cnt = 0;
          do begin
            digs[cnt] = 4'(mag % 10);
            mag = mag / 10;
            cnt++;
          end while (mag != 0 && cnt < clis_pkg::NUM_DIGITS);
          for (int i = cnt - 1; i >= 0; i--)
            push_byte(1'b1, clis_pkg::CHAR_ZERO + 8'(digs[i]), 6'd0);
        end
        default: ;
      endcase
      if (expected_xfers.size() > start)
        expected_xfers[expected_xfers.size() - 1].last = 1'b1;
    endfunction

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    task check_xfer(lcd_xfer_t got);
      lcd_xfer_t want;
      if (expected_xfers.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer bus 0x%0h", got.bus));
      end else begin
        want = expected_xfers.pop_front();
        check_field("register_select", 8'(got.rs), 8'(want.rs));
        check_field("bus_value", got.bus, want.bus);
        check_field("wait_before_ms", 8'(got.wait_ms), 8'(want.wait_ms));
        check_field("settle_after_ms", 8'(got.settle_ms), 8'(want.settle_ms));
        check_field("transfer_valid", 8'(got.xfer), 8'(want.xfer));
        check_field("status", 8'(got.status), 8'(want.status));
        check_field("last", 8'(got.last), 8'(want.last));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i;
  logic [2:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;

  lcd_xfer_scoreboard sb;
  int unsigned in_gap_max  = 7;
  int unsigned out_gap_max = 7;
  int unsigned hold_cycles = 0;

  char_lcd_interface_sequencer dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o,
    .m_axis_tlast_o
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // called at a falling edge, returns at a falling edge
  task send_request(logic [2:0] op, logic [7:0] byte_value, logic [7:0] row,
                    logic [7:0] column, logic [31:0] number);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser_i  = op;
    s_axis_tdata_i  = {number, column, row, byte_value};
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(op, byte_value, row, column, number);
    @(negedge clk_i);
  endtask

  task wait_idle();
    s_axis_tvalid_i = 1'b0;
    while (sb.expected_xfers.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task write_bus_mode(logic mode);
    cfg_wdata_i = mode;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    sb.bus4     = mode;
  endtask

  // count covers only requests that produce output
  task send_random_batch(int unsigned count);
    int unsigned done;
    logic [2:0]  op;
    logic [7:0]  row;
    logic [7:0]  column;
    logic [31:0] number;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 9) == 0)
        op = OP_SPARE_LO + 3'($urandom_range(0, 2));
      else
        op = 3'($urandom_range(clis_pkg::OP_INIT, clis_pkg::OP_INT));
      if ($urandom_range(0, 3) != 0) begin
        row    = 8'($urandom_range(1, clis_pkg::ROWS));
        column = 8'($urandom_range(1, clis_pkg::COLUMNS));
      end else begin
        row    = 8'($urandom);
        column = 8'($urandom);
      end
      case ($urandom_range(0, 3))
        0:       number = $urandom;
        1:       number = $urandom_range(0, 99);
        2:       number = -32'($urandom_range(0, 1000));
        default: number = $urandom >> $urandom_range(0, 31);
      endcase
      send_request(op, 8'($urandom), row, column, number);
      if (op <= clis_pkg::OP_INT) done++;
    end
  endtask

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // result side: random stalls, one long hold on request
  initial begin
    lcd_xfer_t   got;
    int unsigned gap;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_cycles != 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end else begin
        gap = $urandom_range(0, out_gap_max);
      end
      if (gap != 0) begin
        m_axis_tready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      got.rs        = m_axis_tuser_o;
      got.bus       = m_axis_tdata_o[7:0];
      got.wait_ms   = m_axis_tdata_o[13:8];
      got.settle_ms = m_axis_tdata_o[15:14];
      got.xfer      = m_axis_tdata_o[16];
      got.status    = m_axis_tdata_o[17];
      got.last      = m_axis_tlast_o;
      sb.check_xfer(got);
      @(negedge clk_i);
    end
  end

  initial begin
    sb = new();
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = clis_pkg::OP_INIT;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed, four-bit bus out of reset
    send_request(clis_pkg::OP_INIT, 8'h00, 8'd0, 8'd0, 32'd0);
    send_request(clis_pkg::OP_CMD,  8'h00, 8'd0, 8'd0, 32'd0);
    send_request(clis_pkg::OP_CMD,  8'hFF, 8'd0, 8'd0, 32'd0);
    send_request(clis_pkg::OP_DATA, 8'hA5, 8'd0, 8'd0, 32'd0);
    send_request(clis_pkg::OP_DATA, 8'h5A, 8'd0, 8'd0, 32'd0);
    send_request(clis_pkg::OP_GOTO, 8'h00, 8'd1, 8'd1, 32'd0);
    send_request(clis_pkg::OP_GOTO, 8'h00, 8'(clis_pkg::ROWS), 8'(clis_pkg::COLUMNS), 32'd0);
    send_request(clis_pkg::OP_GOTO, 8'h00, 8'd0, 8'd1, 32'd0);  // row below range
    send_request(clis_pkg::OP_GOTO, 8'h00, 8'(clis_pkg::ROWS + 1), 8'd1,
                 32'd0);  // row above range
    send_request(clis_pkg::OP_GOTO, 8'h00, 8'd1, 8'd0, 32'd0);
    send_request(clis_pkg::OP_GOTO, 8'h00, 8'd1, 8'(clis_pkg::COLUMNS + 1), 32'd0);
    send_request(clis_pkg::OP_GOTO, 8'h00, 8'hFF, 8'hFF, 32'd0);
    send_request(clis_pkg::OP_INT,  8'h00, 8'd0, 8'd0, 32'd0);
    send_request(clis_pkg::OP_INT,  8'h00, 8'd0, 8'd0, 32'hFFFF_FFFF);
    send_request(clis_pkg::OP_INT,  8'h00, 8'd0, 8'd0, 32'h7FFF_FFFF);
    send_request(clis_pkg::OP_INT,  8'h00, 8'd0, 8'd0, 32'h8000_0000);  // most negative
    send_request(clis_pkg::OP_INT,  8'h00, 8'd0, 8'd0, 32'd10);
    send_request(OP_SPARE_LO, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_request(OP_SPARE_HI, 8'h00, 8'd0, 8'd0, 32'd0);
    wait_idle();

    // eight-bit bus
    write_bus_mode(1'b0);
    send_request(clis_pkg::OP_INIT, 8'h00, 8'd0, 8'd0, 32'd0);
    send_request(clis_pkg::OP_CMD,  8'hFF, 8'd0, 8'd0, 32'd0);
    send_request(clis_pkg::OP_DATA, 8'h00, 8'd0, 8'd0, 32'd0);
    send_request(clis_pkg::OP_GOTO, 8'h00, 8'(clis_pkg::ROWS), 8'(clis_pkg::COLUMNS), 32'd0);
    send_request(clis_pkg::OP_INT,  8'h00, 8'd0, 8'd0, 32'h8000_0000);
    send_random_batch(BATCH_ITEMS);
    wait_idle();

    // sender runs flat out while the receiver holds off
    write_bus_mode(1'b1);
    in_gap_max  = 0;
    hold_cycles = HOLD_CYCLES;
    send_random_batch(BATCH_ITEMS);
    wait_idle();

    // no idling on either side
    write_bus_mode(1'b0);
    out_gap_max = 0;
    send_random_batch(BATCH_ITEMS);
    wait_idle();

    write_bus_mode(1'b1);
    in_gap_max  = 7;
    out_gap_max = 7;
    send_random_batch(BATCH_ITEMS);
    wait_idle();

    write_bus_mode(1'b0);
    in_gap_max = 3;
    send_random_batch(BATCH_ITEMS);
    wait_idle();

    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
